@@ hw/rtl/frame_receive_parser_defines.svh @@
// Assertion macros used by the frame_receive_parser RTL.
`ifndef FRAME_RECEIVE_PARSER_DEFINES_SVH
`define FRAME_RECEIVE_PARSER_DEFINES_SVH

// Same-cycle implication.
`define FRP_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define FRP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hw/rtl/frp_pkg.sv @@
`timescale 1ns / 1ps
package frp_pkg;

   localparam logic [1:0] CSR_FIRST_MARKER  = 2'd0;
   localparam logic [1:0] CSR_SECOND_MARKER = 2'd1;
   localparam logic [1:0] CSR_COMMAND_KIND  = 2'd2;

   localparam int EXTRA_IDX_W = 7;

   localparam logic [15:0] SEQ_BYTES   = 16'd4;
   localparam logic [15:0] LEN_BYTES   = 16'd2;
   localparam logic [15:0] CHECK_BYTES = 16'd2;
   localparam logic [15:0] HEAD_BYTES  = 16'd5;
   localparam logic [15:0] EXTRA_CAP   = 16'd127;

   typedef enum logic [6:0] {
      ST_HUNT  = 7'b0000001,
      ST_MARK2 = 7'b0000010,
      ST_TYPE  = 7'b0000100,
      ST_SEQ   = 7'b0001000,
      ST_LEN   = 7'b0010000,
      ST_DATA  = 7'b0100000,
      ST_CHECK = 7'b1000000
   } parse_state_type;

   typedef struct packed {
      logic [7:0] first_marker;
      logic [7:0] second_marker;
      logic [7:0] command_kind;
   } csr_type;

   typedef struct packed {
      logic                   frame_done;
      logic                   command_ready;
      logic [7:0]             frame_type;
      logic [31:0]            frame_sequence;
      logic [7:0]             command_code;
      logic [31:0]            command_arg;
      logic [EXTRA_IDX_W-1:0] extra_length;
   } frame_type;

   typedef struct packed {
      logic                   en;
      logic [EXTRA_IDX_W-1:0] addr;
      logic [7:0]             data;
   } extra_wr_type;

   typedef struct packed {
      logic                   en;
      logic [EXTRA_IDX_W-1:0] count;
   } extra_commit_type;

endpackage

@@ hw/rtl/frp_parser.sv @@
`timescale 1ns / 1ps
module frp_parser import frp_pkg::*; #(
   parameter int MAX_PAYLOAD = 256
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             byte_en,
   input  logic [7:0]       data_byte,
   input  csr_type          csr,
   output frame_type        frame,
   output extra_wr_type     wr,
   output extra_commit_type commit
);

   localparam logic [15:0] MaxLen = 16'(MAX_PAYLOAD);

   parse_state_type state_ff, state_in;
   logic [7:0]  kind_ff, kind_in;
   logic [31:0] seq_ff, seq_in;
   logic [15:0] len_ff, len_in;
   logic [15:0] pos_ff, pos_in;
   logic [7:0]  code_ff, code_in;
   logic [31:0] arg_ff, arg_in;

   logic [15:0] pos_inc;
   logic [15:0] new_len;
   logic [15:0] len_extra;
   logic [15:0] extra_pos;
   logic [EXTRA_IDX_W-1:0] extra_count;
   logic is_command;

   assign pos_inc   = pos_ff + 16'd1;
   assign new_len   = {data_byte, len_ff[15:8]};
   assign len_extra = len_ff - HEAD_BYTES;
   assign extra_pos = pos_ff - HEAD_BYTES;
   assign is_command = (kind_ff == csr.command_kind);

   always_comb begin
      if (len_ff < HEAD_BYTES) begin
         extra_count = '0;
      end else if (len_extra > EXTRA_CAP) begin
         extra_count = EXTRA_CAP[EXTRA_IDX_W-1:0];
      end else begin
         extra_count = len_extra[EXTRA_IDX_W-1:0];
      end
   end

   always_comb begin
      state_in = state_ff;
      kind_in  = kind_ff;
      seq_in   = seq_ff;
      len_in   = len_ff;
      pos_in   = pos_ff;
      code_in  = code_ff;
      arg_in   = arg_ff;
      frame    = '0;
      wr.en    = 1'b0;
      wr.addr  = extra_pos[EXTRA_IDX_W-1:0];
      wr.data  = data_byte;
      commit.en    = 1'b0;
      commit.count = extra_count;
      if (byte_en) begin
         unique case (state_ff)
            ST_MARK2: begin
               state_in = (data_byte == csr.second_marker) ? ST_TYPE : ST_HUNT;
            end
            ST_TYPE: begin
               kind_in  = data_byte;
               pos_in   = '0;
               state_in = ST_SEQ;
            end
            ST_SEQ: begin
               seq_in = {data_byte, seq_ff[31:8]};
               pos_in = pos_inc;
               if (pos_inc >= SEQ_BYTES) begin
                  pos_in   = '0;
                  state_in = ST_LEN;
               end
            end
            ST_LEN: begin
               len_in = new_len;
               pos_in = pos_inc;
               if (pos_inc >= LEN_BYTES) begin
                  pos_in   = '0;
                  state_in = (new_len == '0 || new_len > MaxLen) ? ST_HUNT : ST_DATA;
               end
            end
            ST_DATA: begin
               if (pos_ff == '0) begin
                  code_in = data_byte;
               end else if (pos_ff < HEAD_BYTES) begin
                  arg_in = {data_byte, arg_ff[31:8]};
               end
               wr.en  = (pos_ff >= HEAD_BYTES) && (extra_pos < EXTRA_CAP);
               pos_in = pos_inc;
               if (pos_inc >= len_ff) begin
                  pos_in   = '0;
                  state_in = ST_CHECK;
               end
            end
            ST_CHECK: begin
               pos_in = pos_inc;
               if (pos_inc >= CHECK_BYTES) begin
                  pos_in   = '0;
                  state_in = ST_HUNT;
                  frame.frame_done     = 1'b1;
                  frame.frame_type     = kind_ff;
                  frame.frame_sequence = seq_ff;
                  if (is_command) begin
                     commit.en            = 1'b1;
                     frame.command_ready  = 1'b1;
                     frame.command_code   = code_ff;
                     frame.command_arg    = (len_ff < HEAD_BYTES) ? '0 : arg_ff;
                     frame.extra_length   = extra_count;
                  end
               end
            end
            default: begin
               state_in = (data_byte == csr.first_marker) ? ST_MARK2 : ST_HUNT;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_HUNT;
         kind_ff  <= '0;
         seq_ff   <= '0;
         len_ff   <= '0;
         pos_ff   <= '0;
      end else begin
         state_ff <= state_in;
         kind_ff  <= kind_in;
         seq_ff   <= seq_in;
         len_ff   <= len_in;
         pos_ff   <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      code_ff <= code_in;
      arg_ff  <= arg_in;
   end

endmodule

@@ hw/rtl/frp_extra_store.sv @@
`timescale 1ns / 1ps
module frp_extra_store import frp_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  logic                   rd_en,
   input  logic [EXTRA_IDX_W-1:0] rd_index,
   input  extra_wr_type           wr,
   input  extra_commit_type       commit,
   output logic [7:0]             read_data
);

   localparam int Depth = 2 ** (EXTRA_IDX_W + 1);

   logic [7:0] mem [Depth];

   logic                   bank_ff;
   logic [EXTRA_IDX_W-1:0] count_ff;
   logic                   rd_ok_ff, rd_ok_in;
   logic [7:0]             rd_data_ff;

   assign rd_ok_in  = rd_en && (rd_index < count_ff);
   assign read_data = rd_ok_ff ? rd_data_ff : 8'd0;

   // fill the idle bank; committed bank stays readable
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[{~bank_ff, wr.addr}] <= wr.data;
      end
      if (advance) begin
         rd_data_ff <= mem[{bank_ff, rd_index}];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bank_ff  <= 1'b0;
         count_ff <= '0;
         rd_ok_ff <= 1'b0;
      end else begin
         if (commit.en) begin
            bank_ff  <= ~bank_ff;
            count_ff <= commit.count;
         end
         if (advance) begin
            rd_ok_ff <= rd_ok_in;
         end
      end
   end

endmodule

@@ hw/rtl/frame_receive_parser.sv @@
`timescale 1ns / 1ps
// Frame receive parser.
// req channel: one item per received byte (req_operation 0, req_data_byte) or
// a read of the last command's extra payload (req_operation 1, req_read_index).
// rsp channel: exactly one result item per request item, in order. A byte item
// reports frame_done on the second check byte, with the type and sequence
// number, plus command code, argument and extra length for command frames.
// A read item carries only read_data (zero at or beyond the extra length).
// Results are registered: rsp_valid rises in the cycle after req accept. Throughput:
// one item per cycle while results are taken, set by the single result register;
// req_ready stays high while the result register is empty or being taken in the same cycle.
// When rsp_ready is low with a result held, req_ready drops and all state holds.
// Extra payload lives in a two-bank 256 x 8 memory: incoming bytes fill the
// idle bank and a finished command frame swaps banks.
// Reset: synchronous, clears the parser to marker hunt, empties the result
// register, zeroes the marker and command registers and the extra count.
// csr_write with csr_index writes a register; only write while idle.
`include "frame_receive_parser_defines.svh"
module frame_receive_parser import frp_pkg::*; #(
   parameter int MAX_PAYLOAD = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_operation,
   input  logic [7:0]  req_data_byte,
   input  logic [6:0]  req_read_index,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_frame_done,
   output logic        rsp_command_ready,
   output logic [7:0]  rsp_frame_type,
   output logic [31:0] rsp_frame_sequence,
   output logic [7:0]  rsp_command_code,
   output logic [31:0] rsp_command_arg,
   output logic [6:0]  rsp_extra_length,
   output logic [7:0]  rsp_read_data
);

   csr_type          csr_ff;
   frame_type        frame, frame_ff;
   extra_wr_type     wr;
   extra_commit_type commit;
   logic             rsp_valid_ff;
   logic             accept;
   logic             byte_en;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign byte_en   = accept && !req_operation;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_FIRST_MARKER:  csr_ff.first_marker  <= csr_data;
            CSR_SECOND_MARKER: csr_ff.second_marker <= csr_data;
            CSR_COMMAND_KIND:  csr_ff.command_kind  <= csr_data;
            default: begin
            end
         endcase
      end
   end

   frp_parser #(
      .MAX_PAYLOAD(MAX_PAYLOAD)
   ) u_parser (
      .clock    (clock),
      .reset    (reset),
      .byte_en  (byte_en),
      .data_byte(req_data_byte),
      .csr      (csr_ff),
      .frame    (frame),
      .wr       (wr),
      .commit   (commit)
   );

   frp_extra_store u_store (
      .clock    (clock),
      .reset    (reset),
      .advance  (accept),
      .rd_en    (req_operation),
      .rd_index (req_read_index),
      .wr       (wr),
      .commit   (commit),
      .read_data(rsp_read_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         frame_ff <= frame;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_frame_done     = frame_ff.frame_done;
   assign rsp_command_ready  = frame_ff.command_ready;
   assign rsp_frame_type     = frame_ff.frame_type;
   assign rsp_frame_sequence = frame_ff.frame_sequence;
   assign rsp_command_code   = frame_ff.command_code;
   assign rsp_command_arg    = frame_ff.command_arg;
   assign rsp_extra_length   = frame_ff.extra_length;

   `FRP_ASSERT_NEXT(a_accept_gives_rsp, clock, reset, accept, rsp_valid, "accepted item produced no result")
   `FRP_ASSERT_SAME(a_cmd_implies_done, clock, reset, rsp_valid && rsp_command_ready, rsp_frame_done, "command without frame done")
   `FRP_ASSERT_SAME(a_read_excludes_frame, clock, reset, rsp_valid && rsp_read_data != 8'd0, !rsp_frame_done, "read result carries frame fields")
   `FRP_ASSERT_SAME(a_extra_needs_cmd, clock, reset, rsp_valid && rsp_extra_length != 7'd0, rsp_command_ready, "extra length on non-command result")

endmodule
